/* sv/scfp_pkg.sv */
// Shared types, constants and a helper function for the sum-checked frame parser.
package scfp_pkg;

  localparam logic [7:0] HDR_BYTE          = 8'hAA;
  localparam logic [7:0] LEN_BYTE          = 8'h0D;

  // Frame positions
  localparam logic [3:0] POS_HDR           = 4'd0;
  localparam logic [3:0] POS_LEN           = 4'd1;
  localparam logic [3:0] POS_FIRST_PAYLOAD = 4'd2;
  localparam logic [3:0] POS_LAST_PAYLOAD  = 4'd11;
  localparam logic [3:0] POS_CHECK         = 4'd12;

  localparam int unsigned FIRST_PAYLOAD = 2;
  localparam int unsigned LAST_PAYLOAD  = 11;

  localparam int unsigned OUT_TDATA_W   = 88;

  // Decoded frame; first member sits in the top bits.
  typedef struct packed {
    logic [31:0]       good_frames;
    logic signed [8:0] base_dy;
    logic signed [8:0] base_dx;
    logic [7:0]        base_index;
    logic signed [8:0] center_dy;
    logic signed [8:0] center_dx;
    logic [7:0]        target_flag;
  } scfp_result_t;

  localparam int unsigned RESULT_W = $bits(scfp_result_t);

  typedef struct packed {
    logic         valid;
    scfp_result_t data;
  } scfp_res_bus_t;

  // Sign/magnitude pair to 9-bit two's complement; any nonzero sign is negative.
  function automatic logic signed [8:0] sm_to_s9(input logic [7:0] sgn, input logic [7:0] mag);
    logic signed [8:0] m;
    m = $signed({1'b0, mag});
    return (sgn != 8'd0) ? -m : m;
  endfunction

endpackage

/* sv/scfp_parser.sv */
// Frame tracker: position counter, running checksum, payload store and frame decode.
module scfp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            rx_byte,
  output scfp_pkg::scfp_res_bus_t res
);
  import scfp_pkg::*;

  logic [3:0]  pos_r,   pos_nxt;
  logic [7:0]  sum_r,   sum_nxt;
  logic [31:0] tally_r, tally_nxt;
  logic [7:0]  store_r [FIRST_PAYLOAD:LAST_PAYLOAD];
  logic        store_we;
  logic        good;

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    store_we  = 1'b0;
    good      = 1'b0;
    if (byte_en) begin
      if (pos_r == POS_HDR || pos_r > POS_CHECK) begin
        // hunting for the header
        if (rx_byte == HDR_BYTE) begin
          sum_nxt = HDR_BYTE;
          pos_nxt = POS_LEN;
        end else begin
          sum_nxt = 8'd0;
          pos_nxt = POS_HDR;
        end
      end else if (pos_r == POS_LEN) begin
        if (rx_byte == LEN_BYTE) begin
          sum_nxt = sum_r + rx_byte;
          pos_nxt = POS_FIRST_PAYLOAD;
        end else if (rx_byte == HDR_BYTE) begin
          sum_nxt = HDR_BYTE;   // restart on a fresh header
          pos_nxt = POS_LEN;
        end else begin
          sum_nxt = 8'd0;
          pos_nxt = POS_HDR;
        end
      end else if (pos_r <= POS_LAST_PAYLOAD) begin
        store_we = 1'b1;
        sum_nxt  = sum_r + rx_byte;
        pos_nxt  = pos_r + 4'd1;
      end else begin
        // checksum byte
        pos_nxt = POS_HDR;
        sum_nxt = 8'd0;
        if (sum_r == rx_byte) begin
          good      = 1'b1;
          tally_nxt = tally_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HDR;
      sum_r   <= 8'd0;
      tally_r <= 32'd0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = FIRST_PAYLOAD; i <= LAST_PAYLOAD; i++) begin
      if (store_we && pos_r == 4'(i)) begin
        store_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    res.valid            = good;
    res.data.target_flag = store_r[2];
    res.data.center_dx   = sm_to_s9(store_r[3], store_r[4]);
    res.data.center_dy   = sm_to_s9(store_r[5], store_r[6]);
    res.data.base_index  = store_r[7];
    res.data.base_dx     = sm_to_s9(store_r[8], store_r[9]);
    res.data.base_dy     = sm_to_s9(store_r[10], store_r[11]);
    res.data.good_frames = tally_nxt;
  end

endmodule

/* sv/scfp_out_reg.sv */
// Result register holding one decoded frame until the receiver takes it.
module scfp_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scfp_pkg::scfp_res_bus_t res,
  input  logic                    load_en,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [scfp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scfp_pkg::*;

  logic         valid_r, valid_nxt;
  scfp_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_en && res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && res.valid) begin
      data_r <= res.data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), data_r};

endmodule

/* sv/sum_checked_frame_parser.sv */
// Top level of the sum-checked serial frame parser.
//
// Input stream (in_*): one received byte per transfer in in_tdata[7:0].
// The block hunts for header 0xAA followed by 0x0D, collects payload bytes
// 2..11, and compares the 8-bit sum of bytes 0..11 with byte 12. A frame
// that fails the check is dropped without any output.
// Output stream (out_*): one transfer per good frame with the decoded flag,
// the four signed errors, the base index and a wrapping 32-bit frame count.
// The checksum byte is registered in the byte register on its input transfer,
// and its frame is then loaded into the result register that drives out_tvalid.
// Throughput: one byte per cycle unless a pending result stalls on out_tready;
// byte and result registers move together, so both sides may run back to back.
// Stall: while a result waits on out_tready low, one more byte may sit in the
// input register; after that in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): position returns to hunting, the checksum
// and frame count clear, both stream registers empty.
module sum_checked_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] target_flag, [16:8] center_dx, [25:17] center_dy, [33:26] base_index,
  // [42:34] base_dx, [51:43] base_dy, [83:52] good_frames, [87:84] zero
  output logic [scfp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scfp_pkg::*;

  logic          byte_valid_r, byte_valid_nxt;
  logic [7:0]    byte_r;
  logic          advance;
  scfp_res_bus_t res;

  // The byte stage moves on whenever the result register can take a frame.
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !byte_valid_r || advance;

  always_comb begin
    byte_valid_nxt = byte_valid_r;
    if (in_tready) begin
      byte_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  scfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_valid_r && advance),
    .rx_byte (byte_r),
    .res     (res)
  );

  scfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load_en    (byte_valid_r && advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* sv/scfp_checker.sv */
// Port-level checks for the frame parser and their bind to the top level.
module scfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [scfp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scfp_pkg::*;

  logic [31:0] last_cnt_r;
  logic        seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      last_cnt_r <= 32'd0;
    end else if (out_tvalid && out_tready) begin
      seen_r     <= 1'b1;
      last_cnt_r <= out_tdata[83:52];
    end
  end

  // A pending result is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // Frame count steps by one from each delivered frame to the next.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_r |-> out_tdata[83:52] == last_cnt_r + 32'd1)
    else $error("frame count skipped or repeated");

  // With no result pending the byte side never stalls.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:84] == 4'd0)
    else $error("nonzero padding in result");

endmodule

bind sum_checked_frame_parser scfp_checker u_scfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
